FILE: hw/rtl/mcdm_pkg.sv
// Shared constants, payload types and control structs for the mono downmix block.
`timescale 1ns / 1ps

package mcdm_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
    localparam int CFG_CNT_W    = 4;
    localparam int KIND_W       = 2;

    localparam int Q_W      = 33;
    localparam int FRAC_W   = 31;
    localparam int SUM_W    = Q_W + $clog2(MAX_CHANNELS);
    localparam int SCALE_SH = 15;
    localparam int PROD_W   = SUM_W + SCALE_SH;
    localparam int MAG_W    = SUM_W + SCALE_SH - 1;
    localparam int DIV_W    = CNT_W + FRAC_W;
    localparam int QUO_W    = MAG_W - FRAC_W;
    localparam int DSH_W    = DIV_W + QUO_W - 1;
    localparam int STEP_W   = $clog2(QUO_W);

    localparam int PCM_MAX  = 32767;

    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic REG_CHANNEL_COUNT = 1'b0;
    localparam logic REG_SAMPLE_KIND   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_PCM16   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PCM24   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PCM32   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FLOAT32 = 2'd3;

    localparam logic [CFG_CNT_W-1:0] CHANNEL_COUNT_RST = 4'd2;
    localparam logic [KIND_W-1:0]    SAMPLE_KIND_RST   = KIND_PCM16;

    typedef struct packed {
        logic [31:0] sample_word;
        logic        silent;
        logic        packet_last;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] mono_sample;
        logic               packet_end;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic acc;
        logic mul;
        logic step;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic frame_done;
        logic div_last;
    } t_dp_sts;

endpackage

FILE: hw/rtl/mcdm_ctrl.sv
// Sequencer for decode, accumulate, scale, divide and result hand-off.
`timescale 1ns / 1ps

module mcdm_ctrl import mcdm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_RND  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.frame_done ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                if (out_free) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hw/rtl/mcdm_dp.sv
// Datapath: sample decode, frame sum, scale, restoring divide, rounding, result register.
`timescale 1ns / 1ps

module mcdm_dp import mcdm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_in_item             i_item,
    input  logic [CFG_CNT_W-1:0] i_channel_count,
    input  logic [KIND_W-1:0]    i_sample_kind,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output t_out_item            o_item
);

    // decode
    logic [31:0]          w;
    logic [7:0]           f_exp, f_em, f_lsub, f_rsh;
    logic [22:0]          f_man;
    logic [23:0]          f_m24, f_q;
    logic [53:0]          f_t;
    logic [24:0]          f_qr;
    logic [31:0]          f_mag;
    logic                 f_nan, f_neg;
    logic signed [Q_W-1:0] dec_val;
    logic                 dec_nan;

    logic signed [Q_W-1:0]   r_dec;
    logic                    r_nan, r_sil, r_last;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_pos;
    logic                    r_silent;
    logic [MAG_W-1:0]        r_rem;
    logic [DSH_W-1:0]        r_dsh;
    logic [DIV_W-1:0]        r_d;
    logic [QUO_W-1:0]        r_quo;
    logic [STEP_W-1:0]       r_cnt;
    logic                    r_neg;
    t_out_item               r_out;

    logic [CNT_W-1:0]         n_eff, pos_inc;
    logic signed [PROD_W-1:0] prod_se, prod, prod_abs;
    logic [DSH_W-1:0]         rem_ext;
    logic                     ge;
    logic [DIV_W:0]           twice_rem;
    logic                     round_up;
    logic [QUO_W:0]           q_rnd;
    logic signed [15:0]       mag16, res;

    assign w = i_item.sample_word;

    always_comb begin
        f_exp  = w[30:23];
        f_man  = w[22:0];
        f_neg  = w[31];
        f_nan  = (&f_exp) && (|f_man);
        f_em   = (f_exp == 8'd0) ? 8'd1 : f_exp;
        f_m24  = {(f_exp != 8'd0), f_man};
        f_lsub = f_em - 8'd119;
        f_rsh  = 8'd119 - f_em;
        f_t    = {f_m24, 30'b0} >> f_rsh[4:0];
        f_q    = f_t[53:30];
        f_qr   = {1'b0, f_q} + {24'b0, f_t[29] && ((|f_t[28:0]) || f_q[0])};
        if (f_exp >= 8'd127) begin
            f_mag = 32'h8000_0000;
        end else if (f_em >= 8'd119) begin
            f_mag = {8'h00, f_m24} << f_lsub[2:0];
        end else if (f_rsh > 8'd30) begin
            f_mag = '0;
        end else begin
            f_mag = {7'b0, f_qr};
        end

        dec_nan = 1'b0;
        unique case (i_sample_kind)
            KIND_PCM16: dec_val = {w[15], w[15:0], 16'b0};
            KIND_PCM24: dec_val = {w[23], w[23:0], 8'b0};
            KIND_PCM32: dec_val = {w[31], w};
            KIND_FLOAT32: begin
                dec_nan = f_nan;
                if (f_nan) begin
                    dec_val = '0;
                end else if (f_neg) begin
                    dec_val = -$signed({1'b0, f_mag});
                end else begin
                    dec_val = $signed({1'b0, f_mag});
                end
            end
        endcase
    end

    // effective channel count
    always_comb begin
        if (i_channel_count == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(i_channel_count) > 32'(MAX_CHANNELS)) begin
            n_eff = CNT_W'(MAX_CHANNELS);
        end else begin
            n_eff = CNT_W'(i_channel_count);
        end
    end

    assign pos_inc          = r_pos + CNT_W'(1);
    assign o_sts.frame_done = (pos_inc >= n_eff);
    assign o_sts.div_last   = (r_cnt == '0);

    // sum * 32767
    assign prod_se  = PROD_W'(r_sum);
    assign prod     = (prod_se <<< SCALE_SH) - prod_se;
    assign prod_abs = prod[PROD_W-1] ? -prod : prod;

    assign rem_ext  = DSH_W'(r_rem);
    assign ge       = (rem_ext >= r_dsh);

    assign twice_rem = {r_rem[DIV_W-1:0], 1'b0};
    assign round_up  = (twice_rem > {1'b0, r_d}) || ((twice_rem == {1'b0, r_d}) && r_quo[0]);
    assign q_rnd     = {1'b0, r_quo} + {{QUO_W{1'b0}}, round_up};
    assign mag16     = (q_rnd > (QUO_W + 1)'(PCM_MAX)) ? 16'sd32767 : $signed(q_rnd[15:0]);
    assign res       = r_silent ? 16'sd0 : (r_neg ? -mag16 : mag16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_pos    <= '0;
            r_silent <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cmd.acc) begin
                if (!r_nan) begin
                    r_sum <= r_sum + SUM_W'(r_dec);
                end
                r_silent <= r_silent || r_nan || r_sil;
                r_pos    <= pos_inc;
            end
            if (i_cmd.mul) begin
                r_cnt <= STEP_W'(QUO_W - 1);
            end else if (i_cmd.step && (r_cnt != '0)) begin
                r_cnt <= r_cnt - STEP_W'(1);
            end
            if (i_cmd.fin) begin
                r_sum    <= '0;
                r_pos    <= '0;
                r_silent <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dec  <= dec_val;
            r_nan  <= dec_nan;
            r_sil  <= i_item.silent;
            r_last <= i_item.packet_last;
        end
        if (i_cmd.mul) begin
            r_neg <= prod[PROD_W-1];
            r_rem <= prod_abs[MAG_W-1:0];
            r_d   <= {n_eff, {FRAC_W{1'b0}}};
            r_dsh <= DSH_W'({n_eff, {FRAC_W{1'b0}}}) << (QUO_W - 1);
        end
        if (i_cmd.step) begin
            if (ge) begin
                r_rem <= MAG_W'(rem_ext - r_dsh);
            end
            r_quo <= {r_quo[QUO_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.fin) begin
            r_out.mono_sample <= res;
            r_out.packet_end  <= r_last;
        end
    end

    assign o_item = r_out;

endmodule

FILE: hw/rtl/multichannel_to_mono_pcm16_downmix.sv
// Top level: multichannel to mono PCM16 downmix with APB register port.
// Non-final item of a frame: accepted, then input stalls while it is summed.
// Final item: after acceptance it is decoded, summed, scaled, run through a
// 19-step restoring divide and rounded; the result is registered once the output
// is free, and the next request may be taken in the same cycle the result goes valid.
// Synchronous active-low reset clears frame state; registers reset to 2 ch, pcm16.
`timescale 1ns / 1ps

module multichannel_to_mono_pcm16_downmix import mcdm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [CFG_CNT_W-1:0] r_channel_count;
    logic [KIND_W-1:0]    r_sample_kind;
    logic                 wr_en;
    t_dp_cmd              cmd;
    t_dp_sts              sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CHANNEL_COUNT_RST;
            r_sample_kind   <= SAMPLE_KIND_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_CHANNEL_COUNT: r_channel_count <= pwdata[CFG_CNT_W-1:0];
                REG_SAMPLE_KIND:   r_sample_kind   <= pwdata[KIND_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CHANNEL_COUNT: prdata = DATA_W'(r_channel_count);
            REG_SAMPLE_KIND:   prdata = DATA_W'(r_sample_kind);
        endcase
    end

    mcdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mcdm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_in_item),
        .i_channel_count (r_channel_count),
        .i_sample_kind   (r_sample_kind),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_item          (o_out_item)
    );

endmodule
